// File: sv/clt_pkg.sv
// Shared types and constants for the command line tokenizer.
// Used by the channel interfaces, the tokenizer top level and its checker.
package clt_pkg;

   localparam int TEXT_W  = 8;
   localparam int ROLE_W  = 3;
   localparam int CNT_W   = 8;
   localparam int CNT_MAX = 255;

   localparam int MAX_TOKENS_DEFAULT = 255;

   localparam logic [TEXT_W-1:0] CH_SPACE = 8'h20;
   localparam logic [TEXT_W-1:0] CH_DASH  = 8'h2D;
   localparam logic [TEXT_W-1:0] CH_QUOTE = 8'h22;

   typedef enum logic [ROLE_W-1:0] {
      ROLE_CMD        = 3'd0,
      ROLE_SPACE      = 3'd1,
      ROLE_DASH       = 3'd2,
      ROLE_FLAG_CHAR  = 3'd3,
      ROLE_ARG_CHAR   = 3'd4,
      ROLE_QUOTE_OPEN = 3'd5,
      ROLE_QUOTE_CLOSE = 3'd6
   } role_type;

   typedef enum logic [5:0] {
      PH_CMD     = 6'b000001,
      PH_GAP     = 6'b000010,
      PH_FLAG    = 6'b000100,
      PH_ARG     = 6'b001000,
      PH_ARG_GAP = 6'b010000,
      PH_QUOTE   = 6'b100000
   } phase_type;

   function automatic logic is_alnum(input logic [TEXT_W-1:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h30 && c <= 8'h39);
   endfunction

   // Increment that stops at the cap.
   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v,
                                                input logic [CNT_W-1:0] cap);
      return (v < cap) ? v + 1'b1 : cap;
   endfunction

endpackage

// File: sv/clt_req_if.sv
// Input channel of the tokenizer: one text byte per word.
// Depends on clt_pkg for the field widths.
interface clt_req_if import clt_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [TEXT_W-1:0] text_byte;
   logic              line_end;

   modport source (output valid, output text_byte, output line_end, input ready);
   modport sink (input valid, input text_byte, input line_end, output ready);
   modport monitor (input valid, input text_byte, input line_end, input ready);
endinterface

// File: sv/clt_rsp_if.sv
// Result channel of the tokenizer: one role word per text byte.
// Depends on clt_pkg for the field widths.
interface clt_rsp_if import clt_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ROLE_W-1:0] char_role;
   logic              token_start;
   logic [CNT_W-1:0]  token_number;
   logic              line_done;
   logic              parse_status;
   logic [CNT_W-1:0]  flag_total;
   logic [CNT_W-1:0]  arg_total;

   modport source (output valid, output char_role, output token_start,
                   output token_number, output line_done, output parse_status,
                   output flag_total, output arg_total, input ready);
   modport sink (input valid, input char_role, input token_start,
                 input token_number, input line_done, input parse_status,
                 input flag_total, input arg_total, output ready);
   modport monitor (input valid, input char_role, input token_start,
                    input token_number, input line_done, input parse_status,
                    input flag_total, input arg_total, input ready);
endinterface

// File: sv/command_line_tokenizer.sv
// Command line tokenizer top level: classifies each byte of a command line.
// Depends on clt_pkg, clt_req_if and clt_rsp_if.
//
//   channel   direction  word contents
//   req_chan  in         text_byte, line_end
//   rsp_chan  out        char_role, token_start, token_number, line_done,
//                        parse_status, flag_total, arg_total
//
// One byte is accepted per cycle while the result is not stalled; its result
// appears in the result register on the next cycle, one word a cycle.
// The parse phase and counters update on the accepted byte in the same cycle.
// A stalled result holds the register, and a new byte is taken in the cycle
// the held result is taken. Synchronous reset clears the phase and counters,
// as does the final byte of every line.
module command_line_tokenizer import clt_pkg::*; #(
   parameter int MAX_TOKENS = MAX_TOKENS_DEFAULT
) (
   input logic clock,
   input logic reset,
   clt_req_if.sink   req_chan,
   clt_rsp_if.source rsp_chan
);

   localparam logic [CNT_W-1:0] CNT_CAP =
      CNT_W'((MAX_TOKENS < CNT_MAX) ? MAX_TOKENS : CNT_MAX);

   phase_type        phase_ff, phase_in;
   logic [CNT_W-1:0] flag_cnt_ff, flag_cnt_in;
   logic [CNT_W-1:0] arg_cnt_ff, arg_cnt_in;
   logic [CNT_W-1:0] cur_num_ff, cur_num_in;
   logic             first_ff, first_in;

   logic             out_valid_ff;
   logic [ROLE_W-1:0] role_ff;
   logic             start_ff;
   logic [CNT_W-1:0] num_ff;
   logic             done_ff;
   logic             status_ff;
   logic [CNT_W-1:0] flag_tot_ff;
   logic [CNT_W-1:0] arg_tot_ff;

   logic             accept;
   logic [TEXT_W-1:0] c;
   role_type         role;
   logic             start;
   logic [CNT_W-1:0] num;
   logic             open_arg;
   logic             status;

   assign req_chan.ready = !out_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign c              = req_chan.text_byte;

   always_comb begin
      phase_in    = phase_ff;
      flag_cnt_in = flag_cnt_ff;
      arg_cnt_in  = arg_cnt_ff;
      cur_num_in  = cur_num_ff;
      role        = ROLE_CMD;
      start       = 1'b0;
      num         = '0;
      open_arg    = 1'b0;

      unique case (phase_ff)
         PH_CMD: begin
            if (c == CH_SPACE) begin
               role     = ROLE_SPACE;
               phase_in = PH_GAP;
            end else begin
               role  = ROLE_CMD;
               start = first_ff;
            end
         end
         PH_GAP, PH_FLAG: begin
            priority if (c == CH_SPACE) begin
               role     = ROLE_SPACE;
               phase_in = PH_GAP;
            end else if (c == CH_DASH) begin
               // A flag is counted on its dash, even with no letters after it.
               role        = ROLE_DASH;
               start       = 1'b1;
               num         = flag_cnt_ff;
               cur_num_in  = flag_cnt_ff;
               flag_cnt_in = sat_inc(flag_cnt_ff, CNT_CAP);
               phase_in    = PH_FLAG;
            end else if (phase_ff == PH_FLAG && is_alnum(c)) begin
               role = ROLE_FLAG_CHAR;
               num  = cur_num_ff;
            end else begin
               open_arg = 1'b1;
            end
         end
         PH_ARG: begin
            if (c == CH_SPACE) begin
               role     = ROLE_SPACE;
               phase_in = PH_ARG_GAP;
            end else begin
               role = ROLE_ARG_CHAR;
               num  = cur_num_ff;
            end
         end
         PH_QUOTE: begin
            num = cur_num_ff;
            if (c == CH_QUOTE) begin
               // A quoted argument is counted only when it closes.
               role       = ROLE_QUOTE_CLOSE;
               arg_cnt_in = sat_inc(arg_cnt_ff, CNT_CAP);
               phase_in   = PH_ARG_GAP;
            end else begin
               role = ROLE_ARG_CHAR;
            end
         end
         default: begin
            if (c == CH_SPACE) begin
               role     = ROLE_SPACE;
               phase_in = PH_ARG_GAP;
            end else begin
               open_arg = 1'b1;
            end
         end
      endcase

      if (open_arg) begin
         start      = 1'b1;
         num        = arg_cnt_ff;
         cur_num_in = arg_cnt_ff;
         if (c == CH_QUOTE) begin
            role     = ROLE_QUOTE_OPEN;
            phase_in = PH_QUOTE;
         end else begin
            role       = ROLE_ARG_CHAR;
            arg_cnt_in = sat_inc(arg_cnt_ff, CNT_CAP);
            phase_in   = PH_ARG;
         end
      end

      status   = (phase_in == PH_QUOTE);
      first_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_CMD;
         flag_cnt_ff <= '0;
         arg_cnt_ff  <= '0;
         cur_num_ff  <= '0;
         first_ff    <= 1'b1;
      end else if (accept) begin
         if (req_chan.line_end) begin
            phase_ff    <= PH_CMD;
            flag_cnt_ff <= '0;
            arg_cnt_ff  <= '0;
            cur_num_ff  <= '0;
            first_ff    <= 1'b1;
         end else begin
            phase_ff    <= phase_in;
            flag_cnt_ff <= flag_cnt_in;
            arg_cnt_ff  <= arg_cnt_in;
            cur_num_ff  <= cur_num_in;
            first_ff    <= first_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (accept) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         role_ff  <= role;
         start_ff <= start;
         num_ff   <= num;
         done_ff  <= req_chan.line_end;
         if (req_chan.line_end) begin
            status_ff   <= status;
            flag_tot_ff <= flag_cnt_in;
            arg_tot_ff  <= arg_cnt_in;
         end else begin
            status_ff   <= 1'b0;
            flag_tot_ff <= '0;
            arg_tot_ff  <= '0;
         end
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.char_role    = role_ff;
   assign rsp_chan.token_start  = start_ff;
   assign rsp_chan.token_number = num_ff;
   assign rsp_chan.line_done    = done_ff;
   assign rsp_chan.parse_status = status_ff;
   assign rsp_chan.flag_total   = flag_tot_ff;
   assign rsp_chan.arg_total    = arg_tot_ff;

endmodule

// File: sv/clt_checker.sv
// Port-level checks for the command line tokenizer, bound to its top level.
// Depends on clt_pkg, clt_req_if and clt_rsp_if.
module clt_checker import clt_pkg::*; (
   input logic clock,
   input logic reset,
   clt_req_if.sink   req_chan,
   clt_rsp_if.source rsp_chan
);

   // A result word waits until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |=> rsp_chan.valid)
      else $error("result word dropped before it was taken");

   // No result is shown in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("result valid right after reset");

   // Status and totals are zero except on the final byte of a line.
   a_totals_only_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.line_done |->
         rsp_chan.parse_status == 1'b0 && rsp_chan.flag_total == '0 &&
         rsp_chan.arg_total == '0)
      else $error("status or totals set before the end of the line");

   // Only a command char, dash, argument char or opening quote starts a token.
   a_start_roles: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.token_start |->
         rsp_chan.char_role == ROLE_CMD || rsp_chan.char_role == ROLE_DASH ||
         rsp_chan.char_role == ROLE_ARG_CHAR ||
         rsp_chan.char_role == ROLE_QUOTE_OPEN)
      else $error("token start on a role that cannot begin a token");

endmodule

bind command_line_tokenizer clt_checker u_clt_checker (
   .clock    (clock),
   .reset    (reset),
   .req_chan (req_chan),
   .rsp_chan (rsp_chan)
);
